@@ rtl/dnle_pkg.sv @@
// Shared types and constants of the DNS name label encoder.
package dnle_pkg;

  localparam int LEN_W = 6;
  localparam logic [7:0] SEP_RESET = 8'h2E;
  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_END  = 1'b1;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             ovf;
    logic             is_end;
    logic             bank;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  typedef struct packed {
    byte_t data;
    logic  last;
    logic  flag;
  } obyte_t;

endpackage

@@ rtl/dnle_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module dnle_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/dnle_front.sv @@
// Front part: accepts input items, stores label characters and issues flush commands.
module dnle_front #(
  parameter int LabelMax = 62
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              req_type_i,
  input  dnle_pkg::byte_t                   name_char_i,
  input  dnle_pkg::byte_t                   sep_i,
  output logic                              ram_we_o,
  output logic [$clog2(LabelMax+1):0]       ram_waddr_o,
  output dnle_pkg::byte_t                   ram_wdata_o,
  output logic                              cmd_push_o,
  output dnle_pkg::cmd_t                    cmd_o,
  input  logic                              cmd_full_i,
  input  dnle_pkg::rel_t                    rel_i
);
  import dnle_pkg::*;

  localparam int IdxW = $clog2(LabelMax + 1);

  logic [IdxW-1:0] len_q;
  logic            ovf_q;
  logic            bank_q;
  logic [1:0]      busy_q;
  logic            accept;
  logic            is_flush;
  logic            is_char;

  assign in_stall_o = busy_q[bank_q] | cmd_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign is_flush   = (req_type_i == REQ_END) || (name_char_i == sep_i);
  assign is_char    = accept & ~is_flush;

  assign ram_we_o    = is_char && (len_q < IdxW'(LabelMax));
  assign ram_waddr_o = {bank_q, len_q};
  assign ram_wdata_o = name_char_i;

  assign cmd_push_o  = accept & is_flush;
  assign cmd_o.len    = LEN_W'(len_q);
  assign cmd_o.ovf    = ovf_q;
  assign cmd_o.is_end = (req_type_i == REQ_END);
  assign cmd_o.bank   = bank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      ovf_q  <= 1'b0;
      bank_q <= 1'b0;
      busy_q <= '0;
    end else begin
      if (rel_i.valid) begin
        busy_q[rel_i.bank] <= 1'b0;
      end
      if (cmd_push_o) begin
        busy_q[bank_q] <= 1'b1;
        len_q  <= '0;
        ovf_q  <= 1'b0;
        bank_q <= ~bank_q;
      end else if (is_char) begin
        if (len_q < IdxW'(LabelMax)) begin
          len_q <= len_q + IdxW'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/dnle_cmd_fifo.sv @@
// Two-entry queue of flush commands between the front and back parts.
module dnle_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dnle_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output dnle_pkg::cmd_t cmd_o
);
  import dnle_pkg::*;

  cmd_t       ent_q [2];
  logic       wp_q;
  logic       rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

@@ rtl/dnle_back.sv @@
// Back part: turns flush commands into length, character and terminating bytes.
module dnle_back #(
  parameter int LabelMax = 62
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  dnle_pkg::cmd_t              cmd_i,
  output logic                        cmd_pop_o,
  output dnle_pkg::rel_t              rel_o,
  output logic                        ram_re_o,
  output logic [$clog2(LabelMax+1):0] ram_raddr_o,
  input  dnle_pkg::byte_t             ram_rdata_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output dnle_pkg::obyte_t            out_o
);
  import dnle_pkg::*;

  localparam int IdxW = $clog2(LabelMax + 1);

  typedef enum logic [1:0] {
    PH_LEN,
    PH_CHAR,
    PH_END
  } phase_e;

  phase_e          phase_q;
  logic [IdxW-1:0] idx_q;
  logic            s1_valid_q;
  logic            s1_ram_q;
  byte_t           s1_lit_q;
  logic            s1_last_q;
  logic            s1_flag_q;

  obyte_t          obuf_q [2];
  logic            owp_q;
  logic            orp_q;
  logic [1:0]      ocnt_q;

  logic            pop;
  logic [2:0]      total;
  logic            issue;
  logic            done;
  logic            last_char;
  obyte_t          push_data;

  assign pop         = out_valid_o & ~out_stall_i;
  assign total       = {1'b0, ocnt_q} + 3'(s1_valid_q) - 3'(pop);
  assign issue       = cmd_valid_i && (total < 3'd2);
  assign last_char   = (LEN_W'(idx_q) + LEN_W'(1)) == cmd_i.len;

  always_comb begin
    done = 1'b0;
    case (phase_q)
      PH_LEN:  done = (cmd_i.len == '0) && !cmd_i.is_end;
      PH_CHAR: done = last_char && !cmd_i.is_end;
      PH_END:  done = 1'b1;
      default: done = 1'b0;
    endcase
  end

  assign cmd_pop_o   = issue & done;
  assign rel_o.valid = cmd_pop_o;
  assign rel_o.bank  = cmd_i.bank;
  assign ram_re_o    = issue && (phase_q == PH_CHAR);
  assign ram_raddr_o = {cmd_i.bank, idx_q};

  assign push_data.data = s1_ram_q ? ram_rdata_i : s1_lit_q;
  assign push_data.last = s1_last_q;
  assign push_data.flag = s1_flag_q;

  assign out_valid_o = (ocnt_q != 2'd0);
  assign out_o       = obuf_q[orp_q];

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      obuf_q[owp_q] <= push_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_LEN;
      idx_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_ram_q   <= 1'b0;
      s1_lit_q   <= '0;
      s1_last_q  <= 1'b0;
      s1_flag_q  <= 1'b0;
      owp_q      <= 1'b0;
      orp_q      <= 1'b0;
      ocnt_q     <= '0;
    end else begin
      s1_valid_q <= issue;
      if (s1_valid_q) begin
        owp_q <= ~owp_q;
      end
      if (pop) begin
        orp_q <= ~orp_q;
      end
      ocnt_q <= ocnt_q + 2'(s1_valid_q) - 2'(pop);
      if (issue) begin
        case (phase_q)
          PH_LEN: begin
            s1_ram_q  <= 1'b0;
            s1_lit_q  <= 8'(cmd_i.len);
            s1_last_q <= 1'b0;
            s1_flag_q <= cmd_i.ovf;
            idx_q     <= '0;
            if (cmd_i.len != '0) begin
              phase_q <= PH_CHAR;
            end else if (cmd_i.is_end) begin
              phase_q <= PH_END;
            end
          end
          PH_CHAR: begin
            s1_ram_q  <= 1'b1;
            s1_last_q <= 1'b0;
            s1_flag_q <= cmd_i.ovf;
            idx_q     <= idx_q + IdxW'(1);
            if (last_char) begin
              phase_q <= cmd_i.is_end ? PH_END : PH_LEN;
            end
          end
          PH_END: begin
            s1_ram_q  <= 1'b0;
            s1_lit_q  <= '0;
            s1_last_q <= 1'b1;
            s1_flag_q <= 1'b0;
            phase_q   <= PH_LEN;
          end
          default: begin
            phase_q <= PH_LEN;
          end
        endcase
      end
    end
  end

endmodule

@@ rtl/dns_name_label_encoder.sv @@
// Top level of the DNS name label encoder.
// A host name enters one character per item and leaves as DNS labels: a length byte, the
// label's characters, and a zero byte marked last after the end-of-name item. A character
// item is accepted and produces nothing; a separator or end-of-name item is also accepted
// and queues a flush of the current label, which the back part sends at one byte per cycle
// unless out_stall_i holds it back (length byte, then each character read from the label
// store, then, for an end-of-name item, the terminating zero). The label store holds two
// banks, so the next label fills while the previous one drains; input stalls when the bank
// it would fill is still being read or two flushes are already queued. Characters past
// LABEL_MAX are dropped and the label's bytes carry label_too_long.
module dns_name_label_encoder #(
  parameter int LABEL_MAX = 62
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            req_type_i,
  input  logic [7:0]      name_char_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            is_last_o,
  output logic            label_too_long_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [7:0]      separator_char_i
);
  import dnle_pkg::*;

  localparam int IdxW  = $clog2(LABEL_MAX + 1);
  localparam int AddrW = IdxW + 1;
  localparam int Depth = 2 ** AddrW;

  byte_t            sep_q;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  byte_t            ram_wdata;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  byte_t            ram_rdata;
  logic             cmd_push;
  cmd_t             cmd_in;
  logic             cmd_full;
  logic             cmd_pop;
  logic             cmd_valid;
  cmd_t             cmd_head;
  rel_t             rel;
  obyte_t           obyte;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= SEP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      sep_q <= separator_char_i;
    end
  end

  dnle_front #(
    .LabelMax(LABEL_MAX)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .name_char_i(name_char_i),
    .sep_i      (sep_q),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .cmd_full_i (cmd_full),
    .rel_i      (rel)
  );

  dnle_ram #(
    .Width(8),
    .Depth(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  dnle_cmd_fifo u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .cmd_i  (cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .valid_o(cmd_valid),
    .cmd_o  (cmd_head)
  );

  dnle_back #(
    .LabelMax(LABEL_MAX)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd_head),
    .cmd_pop_o  (cmd_pop),
    .rel_o      (rel),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (obyte)
  );

  assign out_byte_o       = obyte.data;
  assign is_last_o        = obyte.last;
  assign label_too_long_o = obyte.flag;

endmodule

@@ rtl/dnle_checker.sv @@
// Port-level assertions for the DNS name label encoder and their binding.
module dnle_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       is_last_o,
  input logic       label_too_long_o
);

  // A stalled item stays offered with the same bytes.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(is_last_o))
    else $error("stalled output item changed");

  // The terminating byte of a name is zero.
  a_last_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_last_o |-> out_byte_o == 8'd0)
    else $error("terminating byte is not zero");

  // The terminating byte never carries the overflow flag.
  a_last_noflag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_last_o |-> !label_too_long_o)
    else $error("terminating byte flagged as too long");

  // A delivered terminating byte is followed by a length byte or nothing, never a second last.
  a_last_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && is_last_o |=> !(out_valid_o && is_last_o))
    else $error("two terminating bytes in a row");

endmodule

bind dns_name_label_encoder dnle_checker u_dnle_checker (.*);
